### design/ott_pkg.sv
// ----------------------------------------------------------------------------
// ott_pkg
// Types and constants shared by the outstanding transaction tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package ott_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int KIND_W    = 2;
    localparam int ID_W      = 16;
    localparam int ADDR_W    = 64;
    localparam int VIOL_W    = 2;
    localparam int TYPE_W    = 2;

    // request kinds
    localparam logic [KIND_W-1:0] REQ_START = 2'd0;
    localparam logic [KIND_W-1:0] REQ_END   = 2'd1;
    localparam logic [KIND_W-1:0] REQ_FLUSH = 2'd2;

    // violation codes
    localparam logic [VIOL_W-1:0] VIOL_UNMATCHED  = 2'd0;
    localparam logic [VIOL_W-1:0] VIOL_INCOMPLETE = 2'd1;
    localparam logic [VIOL_W-1:0] VIOL_OVERFLOW   = 2'd2;

    // transaction type codes
    localparam logic [TYPE_W-1:0] TYPE_READ  = 2'd0;
    localparam logic [TYPE_W-1:0] TYPE_WRITE = 2'd1;
    localparam logic [TYPE_W-1:0] UNKNOWN    = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic              write;
        logic [ADDR_W-1:0] addr;
    } t_entry;

    typedef struct packed {
        logic              start;
        logic              end_op;
        logic              pop;
        logic [ID_W-1:0]   id;
        logic              write;
        logic [ADDR_W-1:0] addr;
    } t_cell_op;

endpackage

`default_nettype wire

### design/ott_req_if.sv
// ----------------------------------------------------------------------------
// ott_req_if
// Request channel of the outstanding transaction tracker.
// ----------------------------------------------------------------------------
`default_nettype none

interface ott_req_if;
    import ott_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   txn_id;
    logic              is_write;
    logic [ADDR_W-1:0] address;

    modport source (output valid, kind, txn_id, is_write, address, input ready);
    modport sink   (input valid, kind, txn_id, is_write, address, output ready);

endinterface

`default_nettype wire

### design/ott_res_if.sv
// ----------------------------------------------------------------------------
// ott_res_if
// Result channel of the outstanding transaction tracker.
// ----------------------------------------------------------------------------
`default_nettype none

interface ott_res_if;
    import ott_pkg::*;

    logic              valid;
    logic              ready;
    logic [VIOL_W-1:0] violation_kind;
    logic [ID_W-1:0]   txn_id_res;
    logic [TYPE_W-1:0] type_code;
    logic [ADDR_W-1:0] address_res;
    logic              last;

    modport source (output valid, violation_kind, txn_id_res, type_code, address_res, last,
                    input ready);
    modport sink   (input valid, violation_kind, txn_id_res, type_code, address_res, last,
                    output ready);

endinterface

`default_nettype wire

### design/ott_cell.sv
// ----------------------------------------------------------------------------
// ott_cell
// One table slot: holds an open transaction, matches ids, shifts left.
// ----------------------------------------------------------------------------
`default_nettype none

module ott_cell (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ott_pkg::t_cell_op i_op,
    input  wire logic             i_left_valid,
    input  wire logic             i_left_hit,
    input  wire ott_pkg::t_entry  i_right,
    output ott_pkg::t_entry       o_entry,
    output logic                  o_hit
);
    import ott_pkg::*;

    logic              r_valid, n_valid;
    logic [ID_W-1:0]   r_id, n_id;
    logic              r_write, n_write;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic              w_hit;

    assign w_hit = i_left_hit | (r_valid && (r_id == i_op.id));

    always_comb begin
        n_valid = r_valid;
        n_id    = r_id;
        n_write = r_write;
        n_addr  = r_addr;
        if (i_op.pop || (i_op.end_op && w_hit)) begin
            n_valid = i_right.valid;
            n_id    = i_right.id;
            n_write = i_right.write;
            n_addr  = i_right.addr;
        end else if (i_op.start && !r_valid && i_left_valid) begin
            n_valid = 1'b1;
            n_id    = i_op.id;
            n_write = i_op.write;
            n_addr  = i_op.addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id    <= n_id;
        r_write <= n_write;
        r_addr  <= n_addr;
    end

    assign o_entry = '{valid: r_valid, id: r_id, write: r_write, addr: r_addr};
    assign o_hit   = w_hit;

endmodule

`default_nettype wire

### design/outstanding_transaction_tracker.sv
// ----------------------------------------------------------------------------
// outstanding_transaction_tracker
// Age-ordered scoreboard of open bus transactions built as a chain of cells.
// ----------------------------------------------------------------------------
// Open transactions sit in a row of DEPTH cells, oldest in cell 0, packed at
// the front. A start or end request is taken whenever the result register is
// free or being drained; an end removes the oldest matching id by shifting
// every later cell one place toward the front in that same cycle. A flush
// request, once taken, streams the open entries out one per cycle through
// cell 0 while the whole row shifts, as long as the result register is free
// or being drained, and no request is taken until the last entry is out.
// A start into a full table and an end with no match each yield one result.
`default_nettype none

module outstanding_transaction_tracker #(
    parameter int DEPTH = ott_pkg::DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ott_req_if.sink    i_req,
    ott_res_if.source  o_res
);
    import ott_pkg::*;

    t_state            r_state, n_state;
    logic              r_out_valid;
    logic [VIOL_W-1:0] r_out_viol, n_out_viol;
    logic [ID_W-1:0]   r_out_id, n_out_id;
    logic [TYPE_W-1:0] r_out_type, n_out_type;
    logic [ADDR_W-1:0] r_out_addr, n_out_addr;
    logic              r_out_last, n_out_last;

    logic              w_out_free;
    logic              w_accept;
    logic              w_emit;
    t_cell_op          w_op;
    t_entry            w_entry [DEPTH];
    t_entry            w_right [DEPTH];
    logic              w_vchain [DEPTH+1];
    logic              w_hchain [DEPTH+1];
    logic [DEPTH-1:0]  w_valid_vec;
    logic              w_full;
    logic              w_any_hit;

    assign w_vchain[0] = 1'b1;
    assign w_hchain[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g + 1 < DEPTH) begin : g_mid
            assign w_right[g] = w_entry[g+1];
        end else begin : g_end
            assign w_right[g] = '0;
        end

        ott_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_op         (w_op),
            .i_left_valid (w_vchain[g]),
            .i_left_hit   (w_hchain[g]),
            .i_right      (w_right[g]),
            .o_entry      (w_entry[g]),
            .o_hit        (w_hchain[g+1])
        );

        assign w_vchain[g+1]  = w_entry[g].valid;
        assign w_valid_vec[g] = w_entry[g].valid;
    end

    assign w_full    = w_entry[DEPTH-1].valid;
    assign w_any_hit = w_hchain[DEPTH];

    assign w_out_free  = !r_out_valid || o_res.ready;
    assign i_req.ready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept    = i_req.valid && i_req.ready;

    always_comb begin
        n_state    = r_state;
        w_emit     = 1'b0;
        n_out_viol = r_out_viol;
        n_out_id   = r_out_id;
        n_out_type = r_out_type;
        n_out_addr = r_out_addr;
        n_out_last = r_out_last;
        w_op       = '{start: 1'b0, end_op: 1'b0, pop: 1'b0, id: i_req.txn_id,
                       write: i_req.is_write, addr: i_req.address};
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_req.kind)
                        REQ_START: begin
                            w_op.start = 1'b1;
                            if (w_full) begin
                                w_emit     = 1'b1;
                                n_out_viol = VIOL_OVERFLOW;
                                n_out_id   = i_req.txn_id;
                                n_out_type = i_req.is_write ? TYPE_WRITE : TYPE_READ;
                                n_out_addr = i_req.address;
                                n_out_last = 1'b1;
                            end
                        end
                        REQ_END: begin
                            w_op.end_op = 1'b1;
                            if (!w_any_hit) begin
                                w_emit     = 1'b1;
                                n_out_viol = VIOL_UNMATCHED;
                                n_out_id   = i_req.txn_id;
                                n_out_type = UNKNOWN;
                                n_out_addr = '0;
                                n_out_last = 1'b1;
                            end
                        end
                        REQ_FLUSH: begin
                            if (w_entry[0].valid) begin
                                n_state = ST_FLUSH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FLUSH: begin
                if (w_out_free) begin
                    w_op.pop   = 1'b1;
                    w_emit     = 1'b1;
                    n_out_viol = VIOL_INCOMPLETE;
                    n_out_id   = w_entry[0].id;
                    n_out_type = w_entry[0].write ? TYPE_WRITE : TYPE_READ;
                    n_out_addr = w_entry[0].addr;
                    n_out_last = !w_right[0].valid;
                    if (!w_right[0].valid) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_free) begin
                r_out_valid <= w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_viol <= n_out_viol;
            r_out_id   <= n_out_id;
            r_out_type <= n_out_type;
            r_out_addr <= n_out_addr;
            r_out_last <= n_out_last;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.violation_kind = r_out_viol;
    assign o_res.txn_id_res     = r_out_id;
    assign o_res.type_code      = r_out_type;
    assign o_res.address_res    = r_out_addr;
    assign o_res.last           = r_out_last;

    // table stays packed at the front
    a_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid_vec & (w_valid_vec + DEPTH'(1))) == '0))
        else $error("open entries not packed");

    // a flush in progress always has an entry in front
    a_flush_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH) |-> w_entry[0].valid)
        else $error("flush with empty front cell");

    // each flush pop removes exactly one entry
    a_flush_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH && w_out_free) |=>
        ($countones(w_valid_vec) + 1 == $past($countones(w_valid_vec))))
        else $error("flush pop count mismatch");

    // a start into a table with room adds one entry
    a_start_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req.kind == REQ_START && !w_full) |=>
        ($countones(w_valid_vec) == $past($countones(w_valid_vec)) + 1))
        else $error("start did not add an entry");

endmodule

`default_nettype wire

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the outstanding transaction tracker.
// ----------------------------------------------------------------------------
// A queue of requests feeds a clocked driver on the request channel. The open
// transaction table is mirrored in the bench at every accepted request, and
// the violation reports it implies are queued. A clocked monitor compares each
// report with the oldest queued one. It runs a directed set first: extremes,
// duplicate ids, a full table and flushes. Random traffic follows in three
// idling phases, with one long stall on the report side in between.
`default_nettype none

module tb;
    import ott_pkg::*;

    localparam int TB_DEPTH = DEPTH_DEF;
    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_LEN = 150;
    localparam int MAX_SHOWN = 40;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic              wr;
        logic [ADDR_W-1:0] addr;
    } t_request;

    typedef struct {
        logic [ID_W-1:0]   id;
        logic              wr;
        logic [ADDR_W-1:0] addr;
    } t_open_txn;

    typedef struct {
        logic [VIOL_W-1:0] viol;
        logic [ID_W-1:0]   id;
        logic [TYPE_W-1:0] type_code;
        logic [ADDR_W-1:0] addr;
        logic              last;
    } t_report;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ott_req_if req_if ();
    ott_res_if res_if ();

    outstanding_transaction_tracker #(.DEPTH(TB_DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    t_request  req_backlog[$];
    t_open_txn open_txns[$];
    t_report   pending_reports[$];

    int n_queued = 0;
    int n_accepted = 0;
    int n_reports = 0;
    int errors = 0;
    int cycles = 0;
    int viol_seen[4] = '{default: 0};
    int tx_idle_pct = 16;
    int rx_idle_pct = 78;
    int hold_req_cnt = 0;
    int hold_ack_cnt = 0;
    int hold_left = 0;

    always #2 i_clk = ~i_clk;

    // mirror of the open table, updated per accepted request
    task automatic track_request(input t_request rq);
        t_report rep;
        t_open_txn ent;
        int hit;
        hit = -1;
        case (rq.kind)
            REQ_START: begin
                if (open_txns.size() >= TB_DEPTH) begin
                    rep = '{VIOL_OVERFLOW, rq.id, rq.wr ? TYPE_WRITE : TYPE_READ, rq.addr, 1'b1};
                    pending_reports.insert(pending_reports.size(), rep);
                end else begin
                    ent = '{rq.id, rq.wr, rq.addr};
                    open_txns.insert(open_txns.size(), ent);
                end
            end
            REQ_END: begin
                for (int i = 0; i < open_txns.size() && hit < 0; i++) begin
                    if (open_txns[i].id == rq.id) hit = i;
                end
                if (hit >= 0) begin
                    open_txns.delete(hit);
                end else begin
                    rep = '{VIOL_UNMATCHED, rq.id, UNKNOWN, '0, 1'b1};
                    pending_reports.insert(pending_reports.size(), rep);
                end
            end
            REQ_FLUSH: begin
                foreach (open_txns[i]) begin
                    rep = '{VIOL_INCOMPLETE, open_txns[i].id,
                            open_txns[i].wr ? TYPE_WRITE : TYPE_READ,
                            open_txns[i].addr, i == open_txns.size() - 1};
                    pending_reports.insert(pending_reports.size(), rep);
                end
                open_txns.delete();
            end
            default: begin
            end
        endcase
    endtask

    // request driver
    always @(posedge i_clk) begin
        t_request rq;
        if (!i_rst_n) begin
            req_if.valid    <= 1'b0;
            req_if.kind     <= REQ_START;
            req_if.txn_id   <= '0;
            req_if.is_write <= 1'b0;
            req_if.address  <= '0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                rq = '{req_if.kind, req_if.txn_id, req_if.is_write, req_if.address};
                track_request(rq);
                n_accepted++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (req_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    rq = req_backlog.pop_front();
                    req_if.valid    <= 1'b1;
                    req_if.kind     <= rq.kind;
                    req_if.txn_id   <= rq.id;
                    req_if.is_write <= rq.wr;
                    req_if.address  <= rq.addr;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // report receiver with a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (hold_req_cnt != hold_ack_cnt) begin
            hold_ack_cnt <= hold_req_cnt;
            hold_left <= HOLD_LEN;
            res_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic check_field(input string fname, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= MAX_SHOWN)
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, fname, want, got);
        end
    endtask

    // report monitor
    always @(posedge i_clk) begin
        t_report rep;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            n_reports++;
            viol_seen[res_if.violation_kind]++;
            if (pending_reports.size() == 0) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("%0t: unexpected report, expected none, actual kind %0d id %0h",
                             $time, res_if.violation_kind, res_if.txn_id_res);
            end else begin
                rep = pending_reports.pop_front();
                check_field("violation_kind", 64'(rep.viol), 64'(res_if.violation_kind));
                check_field("txn_id", 64'(rep.id), 64'(res_if.txn_id_res));
                check_field("type_code", 64'(rep.type_code), 64'(res_if.type_code));
                check_field("address", rep.addr, res_if.address_res);
                check_field("last", 64'(rep.last), 64'(res_if.last));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic add_request(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                               input logic wr, input logic [ADDR_W-1:0] addr);
        t_request rq;
        rq = '{kind, id, wr, addr};
        req_backlog.insert(req_backlog.size(), rq);
        n_queued++;
    endtask

    function automatic logic [ADDR_W-1:0] rand_addr();
        return {$urandom, $urandom};
    endfunction

    // mostly starts and ends over a small id pool so ends hit and duplicates occur
    task automatic add_random_traffic(input int count);
        logic [ID_W-1:0] pool[8];
        logic [ID_W-1:0] id;
        int r;
        int n;
        n = 0;
        foreach (pool[i]) pool[i] = ID_W'($urandom_range(16'hFFFF));
        while (n < count) begin
            r = $urandom_range(99);
            id = ($urandom_range(5) == 0) ? ID_W'($urandom_range(16'hFFFF))
                                           : pool[$urandom_range(7)];
            if (r < 48) begin
                add_request(REQ_START, id, 1'($urandom_range(1)), rand_addr());
                n++;
            end else if (r < 88) begin
                add_request(REQ_END, id, 1'($urandom_range(1)), rand_addr());
                n++;
            end else if (r < 95) begin
                add_request(REQ_FLUSH, id, 1'($urandom_range(1)), rand_addr());
                n++;
            end else begin
                add_request(KIND_UNUSED, id, 1'($urandom_range(1)), rand_addr());
            end
        end
    endtask

    task automatic wait_drained();
        while (n_accepted != n_queued || pending_reports.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty flush, unused kind, unmatched end, extremes, duplicates
        add_request(REQ_FLUSH, '0, 1'b0, '0);
        add_request(KIND_UNUSED, 16'hFFFF, 1'b1, '1);
        add_request(REQ_END, 16'hFFFF, 1'b0, '0);
        add_request(REQ_START, 16'h0000, 1'b0, '0);
        add_request(REQ_START, 16'hFFFF, 1'b1, '1);
        add_request(REQ_START, 16'h1234, 1'b1, 64'h0123_4567_89AB_CDEF);
        add_request(REQ_START, 16'h1234, 1'b0, 64'hFEDC_BA98_7654_3210);
        add_request(REQ_END, 16'h1234, 1'b0, '0);
        add_request(REQ_END, 16'h0000, 1'b1, '1);
        // fill the table, overflow it, then flush everything
        for (int i = 0; i < TB_DEPTH - 2; i++)
            add_request(REQ_START, ID_W'(16'h4000 + i), i[0], rand_addr());
        add_request(REQ_START, 16'hAAAA, 1'b1, 64'hAAAA_5555_AAAA_5555);
        add_request(REQ_FLUSH, '0, 1'b0, '0);
        wait_drained();

        add_random_traffic(75);
        wait_drained();

        tx_idle_pct = 78;
        rx_idle_pct = 16;
        add_random_traffic(75);
        wait_drained();

        // receiver stalls for a long stretch while ends keep coming
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req_cnt++;
        add_request(REQ_FLUSH, '0, 1'b0, '0);
        for (int i = 0; i < 24; i++)
            add_request(REQ_END, ID_W'($urandom_range(16'hFFFF)), 1'($urandom_range(1)),
                        rand_addr());
        wait_drained();

        add_random_traffic(75);
        wait_drained();
        repeat (40) @(posedge i_clk);

        if (pending_reports.size() != 0) begin
            errors++;
            $display("%0t: %0d expected reports never arrived", $time,
                     pending_reports.size());
        end
        $display("covered %0d requests and %0d reports: %0d unmatched ends,", n_accepted,
                 n_reports, viol_seen[VIOL_UNMATCHED]);
        $display("%0d incomplete at flush, %0d overflows", viol_seen[VIOL_INCOMPLETE],
                 viol_seen[VIOL_OVERFLOW]);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
